// ===== rtl/rmq_pkg.sv =====
// rmq_pkg: types and constants for the matrix to quaternion core
// used by the top level module only; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

  localparam int unsigned FracBitsDefault = 14;
  localparam int unsigned EntryWidth      = 16;

  typedef struct packed {
    logic signed [EntryWidth-1:0] r00;
    logic signed [EntryWidth-1:0] r01;
    logic signed [EntryWidth-1:0] r02;
    logic signed [EntryWidth-1:0] r10;
    logic signed [EntryWidth-1:0] r11;
    logic signed [EntryWidth-1:0] r12;
    logic signed [EntryWidth-1:0] r20;
    logic signed [EntryWidth-1:0] r21;
    logic signed [EntryWidth-1:0] r22;
  } matrix_t;

  typedef struct packed {
    logic signed [EntryWidth-1:0] quat_x;
    logic signed [EntryWidth-1:0] quat_y;
    logic signed [EntryWidth-1:0] quat_z;
    logic signed [EntryWidth-1:0] quat_w;
    logic                         degenerate;
  } quat_t;

  // which component leads
  typedef enum logic [1:0] {
    LEAD_X = 2'd0,
    LEAD_Y = 2'd1,
    LEAD_Z = 2'd2,
    LEAD_W = 2'd3
  } lead_t;

endpackage
`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion_core.sv =====
// rotation_matrix_to_quaternion_core: top level, Spurrier matrix to quaternion
// depends on rmq_pkg, rmq_sqrt_cell and rmq_div_cell
`timescale 1ns / 1ps
`default_nettype none
// usage
//   in channel: in_valid/in_ready with one rmq_pkg::matrix_t item (nine Q1.14
//   entries). out channel: out_valid/out_ready with one rmq_pkg::quat_t item.
//   exactly one result item per input item, in order.
// structure
//   front stage picks the lead component, radicand and three numerators;
//   a row of sqrt cells retires two radicand bits each; a row of divide cells
//   produces one quotient bit per cell for all three numerators at once;
//   a final stage rounds, saturates and fills the output register.
// timing
//   an item passes the front stage, the sqrt cells, the divide cells and the
//   final stage in that order; one item per cycle sustained while the
//   receiver does not stall, the rate is set by the cell chains which each
//   advance on every cycle that the output register is free or being taken.
// stall and reset
//   the whole chain advances only while the output register is free or being
//   taken; when the receiver stalls everything holds and in_ready drops.
//   rst (synchronous) empties every stage; payload registers are not cleared.
module rotation_matrix_to_quaternion_core #(
  parameter int unsigned FRAC_BITS = rmq_pkg::FracBitsDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rmq_pkg::matrix_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rmq_pkg::quat_t       out_data
);

  localparam int unsigned F   = FRAC_BITS;
  // positive radicand stays below 2^AW ; a << F below 2^(AW+F)
  localparam int unsigned AW  = (F + 3 > 17) ? F + 3 : 17;
  localparam int unsigned SQS = (AW + F + 1) / 2;      // sqrt cells
  localparam int unsigned RW  = 2 * SQS;               // radicand width (even)
  localparam int unsigned SW  = SQS + 2;               // root register width
  localparam int unsigned NW  = 19;                    // numerator, signed
  localparam int unsigned DW  = SQS + 2;               // divisor 2s
  localparam int unsigned QW  = 19;                    // unused; the quotient width is DIVS
  localparam int unsigned DVN = NW - 1 + F + 1;        // 2*|n|<<F width
  localparam int unsigned XW  = DW + DVN;              // rem+dividend width
  localparam int unsigned CW  = 2 + 1 + 3;             // lead, degen, signs

  logic adv;

  // ---------------- front stage ----------------
  logic signed [17:0] t;
  logic signed [NW-1:0] n0, n1, n2;
  logic signed [AW:0]   arad;
  rmq_pkg::lead_t       lead;

  always_comb begin
    logic signed [17:0] a00, a11, a22;
    a00 = 18'(in_data.r00);
    a11 = 18'(in_data.r11);
    a22 = 18'(in_data.r22);
    t   = a00 + a11 + a22;
    if (t > a00 && t > a11 && t > a22) begin
      lead = rmq_pkg::LEAD_W;
      arad = (AW+1)'(1 <<< F) + (AW+1)'(t);
      n0 = NW'(in_data.r21) - NW'(in_data.r12);
      n1 = NW'(in_data.r02) - NW'(in_data.r20);
      n2 = NW'(in_data.r10) - NW'(in_data.r01);
    end else if (a22 >= a00 && a22 >= a11) begin
      lead = rmq_pkg::LEAD_Z;
      arad = (AW+1)'(a22 <<< 1) + (AW+1)'(1 <<< F) - (AW+1)'(t);
      n0 = NW'(in_data.r02) + NW'(in_data.r20);  // x
      n1 = NW'(in_data.r12) + NW'(in_data.r21);  // y
      n2 = NW'(in_data.r10) - NW'(in_data.r01);  // w
    end else if (a11 >= a00) begin
      lead = rmq_pkg::LEAD_Y;
      arad = (AW+1)'(a11 <<< 1) + (AW+1)'(1 <<< F) - (AW+1)'(t);
      n0 = NW'(in_data.r01) + NW'(in_data.r10);  // x
      n1 = NW'(in_data.r21) + NW'(in_data.r12);  // z
      n2 = NW'(in_data.r02) - NW'(in_data.r20);  // w
    end else begin
      lead = rmq_pkg::LEAD_X;
      arad = (AW+1)'(a00 <<< 1) + (AW+1)'(1 <<< F) - (AW+1)'(t);
      n0 = NW'(in_data.r10) + NW'(in_data.r01);  // y
      n1 = NW'(in_data.r20) + NW'(in_data.r02);  // z
      n2 = NW'(in_data.r21) - NW'(in_data.r12);  // w
    end
  end

  logic              f_vld;
  logic [RW-1:0]     f_rad;
  logic [CW-1:0]     f_ctl;
  logic [3*NW-1:0]   f_num;
  logic              f_deg;

  always_comb f_deg = (arad <= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (adv) begin
      f_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_rad <= f_deg ? '0 : RW'({arad[AW-1:0], F'(0)});
      f_ctl <= {lead, f_deg, n2[NW-1], n1[NW-1], n0[NW-1]};
      f_num <= {n2, n1, n0};
    end
  end

  // ---------------- square root chain ----------------
  logic              s_vld  [SQS+1];
  logic [RW-1:0]     s_rem  [SQS+1];
  logic [RW-1:0]     s_rad  [SQS+1];
  logic [SW-1:0]     s_root [SQS+1];
  logic [CW-1:0]     s_ctl  [SQS+1];
  logic [3*NW-1:0]   s_num  [SQS+1];

  assign s_vld[0]  = f_vld;
  assign s_rem[0]  = '0;
  assign s_rad[0]  = f_rad;
  assign s_root[0] = '0;
  assign s_ctl[0]  = f_ctl;
  assign s_num[0]  = f_num;

  for (genvar g = 0; g < SQS; g++) begin : g_sqrt
    rmq_sqrt_cell #(.RW(RW), .NW(NW), .SW(SW), .CW(CW)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .vld_in(s_vld[g]), .rem_in(s_rem[g]), .rad_in(s_rad[g]),
      .root_in(s_root[g]), .ctl_in(s_ctl[g]), .num_in(s_num[g]),
      .vld(s_vld[g+1]), .rem(s_rem[g+1]), .rad(s_rad[g+1]),
      .root(s_root[g+1]), .ctl(s_ctl[g+1]), .num(s_num[g+1])
    );
  end

  // ---------------- divide setup ----------------
  // q = (|n|<<F + s) / (2s) ; dividend = 2|n|<<F + 2s = 2(|n|<<F + s) -> use
  // dividend (|n|<<F)+s over divisor 2s
  logic [DW-1:0]   dv_init;
  logic [3*XW-1:0] x_init;
  logic [SW-1:0]   s_fin;

  always_comb begin
    logic [NW-1:0] mag;
    s_fin   = s_root[SQS];
    dv_init = DW'({s_fin, 1'b0});
    for (int i = 0; i < 3; i++) begin
      mag = s_ctl[SQS][i] ? NW'(-s_num[SQS][i*NW +: NW]) : s_num[SQS][i*NW +: NW];
      x_init[i*XW +: XW] = XW'((DVN'(mag) << F) + DVN'(s_fin));
    end
  end

  // dividend sits in low bits, shifted in from the top each cell
  localparam int unsigned DIVS = DVN;
  logic              v_vld [DIVS+1];
  logic [DW-1:0]     v_dvs [DIVS+1];
  logic [3*XW-1:0]   v_rem [DIVS+1];
  logic [3*DIVS-1:0] v_quo [DIVS+1];
  logic [CW+SW-1:0]  v_ctl [DIVS+1];

  assign v_vld[0] = s_vld[SQS];
  assign v_dvs[0] = dv_init;
  assign v_rem[0] = x_init;
  assign v_quo[0] = '0;
  assign v_ctl[0] = {s_ctl[SQS], s_fin};

  for (genvar g = 0; g < DIVS; g++) begin : g_div
    rmq_div_cell #(.QW(DIVS), .DW(DW), .NW(XW), .CW(CW+SW)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .vld_in(v_vld[g]), .dvs_in(v_dvs[g]), .rem_in(v_rem[g]),
      .quo_in(v_quo[g]), .ctl_in(v_ctl[g]),
      .vld(v_vld[g+1]), .dvs(v_dvs[g+1]), .rem(v_rem[g+1]),
      .quo(v_quo[g+1]), .ctl(v_ctl[g+1])
    );
  end

  // ---------------- output stage ----------------
  rmq_pkg::quat_t res;

  function automatic logic signed [15:0] sat_q(input logic [DIVS-1:0] q, input logic neg);
    logic [DIVS-1:0] c;
    c = (q > DIVS'(65536)) ? DIVS'(65536) : q;
    if (neg) sat_q = (c >= DIVS'(32768)) ? 16'sh8000 : -$signed(16'(c));
    else     sat_q = (c >= DIVS'(32767)) ? 16'sh7fff : $signed(16'(c));
  endfunction

  always_comb begin
    logic [CW-1:0]          c;
    logic [SW-1:0]          s;
    logic [SW-1:0]          ld;
    logic signed [15:0]     qa, qb, qc, ql;
    {c, s} = v_ctl[DIVS];
    ld = (s + SW'(1)) >> 1;
    ql = (ld > SW'(32767)) ? 16'sh7fff : $signed(16'(ld));
    qa = sat_q(v_quo[DIVS][0*DIVS +: DIVS], c[0]);
    qb = sat_q(v_quo[DIVS][1*DIVS +: DIVS], c[1]);
    qc = sat_q(v_quo[DIVS][2*DIVS +: DIVS], c[2]);
    res.degenerate = c[3];
    unique case (rmq_pkg::lead_t'(c[5:4]))
      rmq_pkg::LEAD_W: begin
        res.quat_x = qa; res.quat_y = qb; res.quat_z = qc; res.quat_w = ql;
      end
      rmq_pkg::LEAD_Z: begin
        res.quat_x = qa; res.quat_y = qb; res.quat_z = ql; res.quat_w = qc;
      end
      rmq_pkg::LEAD_Y: begin
        res.quat_x = qa; res.quat_y = ql; res.quat_z = qb; res.quat_w = qc;
      end
      default: begin
        res.quat_x = ql; res.quat_y = qa; res.quat_z = qb; res.quat_w = qc;
      end
    endcase
    if (c[3]) begin
      res.quat_x = '0; res.quat_y = '0; res.quat_z = '0; res.quat_w = '0;
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v_vld[DIVS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rmq_sqrt_cell.sv =====
// rmq_sqrt_cell: one restoring square root step, two radicand bits per cycle while en is high
// depends on rmq_pkg only through the parent's widths
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt_cell #(
  parameter int unsigned RW  = 40,
  parameter int unsigned NW  = 18,
  parameter int unsigned SW  = 20,
  parameter int unsigned CW  = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          vld_in,
  input  wire logic [RW-1:0] rem_in,
  input  wire logic [RW-1:0] rad_in,
  input  wire logic [SW-1:0] root_in,
  input  wire logic [CW-1:0] ctl_in,
  input  wire logic [3*NW-1:0] num_in,
  output logic               vld,
  output logic [RW-1:0]      rem,
  output logic [RW-1:0]      rad,
  output logic [SW-1:0]      root,
  output logic [CW-1:0]      ctl,
  output logic [3*NW-1:0]    num
);

  logic [RW-1:0] acc;
  logic [RW-1:0] trial;
  logic          take;

  always_comb begin
    acc   = {rem_in[RW-3:0], rad_in[RW-1 -: 2]};
    trial = {root_in[SW-3:0], 2'b01};
    take  = (acc >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= take ? acc - trial : acc;
      rad  <= {rad_in[RW-3:0], 2'b00};
      root <= {root_in[SW-2:0], take};
      ctl  <= ctl_in;
      num  <= num_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rmq_div_cell.sv =====
// rmq_div_cell: one restoring division step for three numerators sharing a divisor
// depends on no package; widths come from the parent's parameters
`timescale 1ns / 1ps
`default_nettype none
module rmq_div_cell #(
  parameter int unsigned QW = 18,
  parameter int unsigned DW = 21,
  parameter int unsigned NW = 40,
  parameter int unsigned CW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            vld_in,
  input  wire logic [DW-1:0]   dvs_in,
  input  wire logic [3*NW-1:0] rem_in,
  input  wire logic [3*QW-1:0] quo_in,
  input  wire logic [CW-1:0]   ctl_in,
  output logic                 vld,
  output logic [DW-1:0]        dvs,
  output logic [3*NW-1:0]      rem,
  output logic [3*QW-1:0]      quo,
  output logic [CW-1:0]        ctl
);

  // rem holds {partial remainder, remaining dividend bits}
  logic [3*NW-1:0] rem_nx;
  logic [3*QW-1:0] quo_nx;

  always_comb begin
    logic [NW-1:0] sh;
    logic [DW:0]   top;
    for (int i = 0; i < 3; i++) begin
      sh  = {rem_in[i*NW +: NW-1], 1'b0};
      top = {1'b0, sh[NW-1 -: DW]};
      if (top >= {1'b0, dvs_in}) begin
        rem_nx[i*NW +: NW] = {top[DW-1:0] - dvs_in, sh[NW-DW-1:0]};
        quo_nx[i*QW +: QW] = {quo_in[i*QW +: QW-1], 1'b1};
      end else begin
        rem_nx[i*NW +: NW] = sh;
        quo_nx[i*QW +: QW] = {quo_in[i*QW +: QW-1], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvs <= dvs_in;
      rem <= rem_nx;
      quo <= quo_nx;
      ctl <= ctl_in;
    end
  end

endmodule
`default_nettype wire
